/* hw/rtl/mdds_pkg.sv */
// ----------------------------------------------------------------------------
// mdds_pkg
// Shared types and constants for the multiplexed digit display scanner.
// ----------------------------------------------------------------------------
package mdds_pkg;

  localparam logic [2:0] OP_TICK         = 3'd0;
  localparam logic [2:0] OP_WRITE_NUMBER = 3'd1;
  localparam logic [2:0] OP_WRITE_CODE   = 3'd2;
  localparam logic [2:0] OP_SET_DOT      = 3'd3;
  localparam logic [2:0] OP_SET_ENABLE   = 3'd4;
  localparam logic [2:0] OP_BLANK_DIGIT  = 3'd5;

  localparam logic [4:0]  BLANK_CODE = 5'd10;
  localparam logic [15:0] DIV10_MUL  = 16'hCCCD;
  localparam int          DIV10_SHR  = 19;

  typedef struct packed {
    logic [2:0]  operation;
    logic [15:0] number;
    logic [1:0]  position;
    logic [2:0]  digit_count;
    logic [4:0]  glyph_code;
    logic        flag;
  } in_word_t;

  typedef struct packed {
    logic [1:0] active_digit;
    logic       digit_power;
    logic [4:0] active_code;
    logic       dot_level;
  } out_word_t;

  typedef struct packed {
    logic tick;
    logic load_number;
    logic step;
    logic write_code;
    logic set_dot;
    logic set_enable;
    logic blank;
  } ctl_cmd_t;

  typedef struct packed {
    logic left_zero;
    logic left_one;
  } dp_status_t;

endpackage

/* hw/rtl/mdds_ctrl.sv */
// ----------------------------------------------------------------------------
// mdds_ctrl
// Controller: input handshake, digit loop sequencing and output valid.
// ----------------------------------------------------------------------------
module mdds_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [2:0]          in_op,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  mdds_pkg::dp_status_t status,
  output mdds_pkg::ctl_cmd_t   cmd
);

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_DIGIT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;
  logic   is_tick;

  assign is_tick  = (in_op == mdds_pkg::OP_TICK);
  assign in_stall = (state_r != ST_IDLE) | (out_valid_r & out_stall & is_tick);
  assign accept   = in_valid & ~in_stall;

  always_comb begin
    cmd             = '0;
    cmd.tick        = accept & is_tick;
    cmd.load_number = accept & (in_op == mdds_pkg::OP_WRITE_NUMBER);
    cmd.write_code  = accept & (in_op == mdds_pkg::OP_WRITE_CODE);
    cmd.set_dot     = accept & (in_op == mdds_pkg::OP_SET_DOT);
    cmd.set_enable  = accept & (in_op == mdds_pkg::OP_SET_ENABLE);
    cmd.blank       = accept & (in_op == mdds_pkg::OP_BLANK_DIGIT);
    cmd.step        = (state_r == ST_DIGIT) & ~status.left_zero;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd.load_number) state_nxt = ST_DIGIT;
      end
      ST_DIGIT: begin
        if (status.left_zero | status.left_one) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.tick) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* hw/rtl/mdds_dpath.sv */
// ----------------------------------------------------------------------------
// mdds_dpath
// Datapath: glyph and dot stores, scan position, divide-by-ten digit unit
// and the output word register.
// ----------------------------------------------------------------------------
module mdds_dpath #(
  parameter int DIGIT_COUNT = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mdds_pkg::in_word_t   in_data,
  input  mdds_pkg::ctl_cmd_t   cmd,
  output mdds_pkg::dp_status_t status,
  output mdds_pkg::out_word_t  out_data
);

  localparam int IW = $clog2(DIGIT_COUNT);

  logic [4:0]    glyph_r [DIGIT_COUNT];
  logic          dot_r   [DIGIT_COUNT];
  logic [IW-1:0] scan_r, scan_nxt;
  logic          display_on_r;
  logic [15:0]   num_r;
  logic [1:0]    pos_r;
  logic [2:0]    left_r;
  mdds_pkg::out_word_t out_r;

  logic [31:0]   prod;
  logic [15:0]   quot;
  logic [15:0]   quot_x10;
  logic [3:0]    rem;
  logic [2:0]    pos_span;
  logic [2:0]    left_init;
  logic          in_pos_ok;
  logic          step_pos_ok;
  logic [IW-1:0] in_idx;
  logic [IW-1:0] step_idx;

  // divide by ten through reciprocal multiply
  assign prod     = 32'(num_r) * 32'(mdds_pkg::DIV10_MUL);
  assign quot     = 16'(prod >> mdds_pkg::DIV10_SHR);
  assign quot_x10 = (quot << 3) + (quot << 1);
  assign rem      = 4'(num_r - quot_x10);

  assign pos_span  = {1'b0, in_data.position} + 3'd1;
  assign left_init = (in_data.digit_count < pos_span) ? in_data.digit_count : pos_span;

  assign in_pos_ok   = (32'(in_data.position) < DIGIT_COUNT);
  assign step_pos_ok = (32'(pos_r) < DIGIT_COUNT);
  assign in_idx      = IW'(in_data.position);
  assign step_idx    = IW'(pos_r);

  assign status.left_zero = (left_r == 3'd0);
  assign status.left_one  = (left_r == 3'd1);

  always_comb begin
    scan_nxt = scan_r;
    if (display_on_r) begin
      scan_nxt = (scan_r == IW'(DIGIT_COUNT - 1)) ? '0 : scan_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIGIT_COUNT; i++) begin
        glyph_r[i] <= mdds_pkg::BLANK_CODE;
        dot_r[i]   <= 1'b1;
      end
      scan_r       <= '0;
      display_on_r <= 1'b1;
      left_r       <= '0;
    end else begin
      if (cmd.tick) scan_r <= scan_nxt;
      if (cmd.set_enable) display_on_r <= in_data.flag;
      if (cmd.write_code && in_pos_ok) glyph_r[in_idx] <= in_data.glyph_code;
      if (cmd.blank && in_pos_ok) glyph_r[in_idx] <= mdds_pkg::BLANK_CODE;
      if (cmd.set_dot && in_pos_ok) dot_r[in_idx] <= ~in_data.flag;
      if (cmd.load_number) begin
        left_r <= left_init;
      end else if (cmd.step) begin
        left_r <= left_r - 3'd1;
        if (step_pos_ok) glyph_r[step_idx] <= {1'b0, rem};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_number) begin
      num_r <= in_data.number;
      pos_r <= in_data.position;
    end else if (cmd.step) begin
      num_r <= quot;
      pos_r <= pos_r - 2'd1;
    end
    if (cmd.tick) begin
      out_r.active_digit <= 2'(scan_nxt);
      out_r.digit_power  <= display_on_r;
      out_r.active_code  <= glyph_r[scan_nxt];
      out_r.dot_level    <= dot_r[scan_nxt];
    end
  end

  assign out_data = out_r;

endmodule

/* hw/rtl/multiplexed_digit_display_scanner_top.sv */
// ----------------------------------------------------------------------------
// multiplexed_digit_display_scanner_top
// Digit display scanner: glyph and dot stores, decimal number writes and
// a scan position that advances on each tick while the display is on.
// ----------------------------------------------------------------------------
// Tick: the scan word is registered when the tick is accepted, and out_valid rises with it.
// write_number: one divide-by-ten step per cycle in the digit loop, writing
//   min(count, position + 1) digits; input stalls until the loop is done.
// Other words are applied when accepted. One word is worked on at a time.
// Reset (synchronous, rst_n low): glyphs blank, dots dark, scan at 0, on.
// ----------------------------------------------------------------------------
module multiplexed_digit_display_scanner_top #(
  parameter int DIGIT_COUNT = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  mdds_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output mdds_pkg::out_word_t out_data
);

  mdds_pkg::ctl_cmd_t   cmd;
  mdds_pkg::dp_status_t status;

  mdds_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_data.operation),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  mdds_dpath #(
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .status   (status),
    .out_data (out_data)
  );

endmodule

/* tb/mdds_checker.sv */
// ----------------------------------------------------------------------------
// mdds_checker
// Watches both channels of the digit display scanner. Every accepted input
// word updates its own copy of the glyph, dot, scan and enable state, and
// each tick queues the scan word it should produce. Each accepted result
// word is compared field by field with the oldest queued word.
// ----------------------------------------------------------------------------
module mdds_checker #(
  parameter int DIGIT_COUNT = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  mdds_pkg::in_word_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  mdds_pkg::out_word_t out_data,
  output int                  fail_count,
  output int                  pending_words
);

  logic [4:0]          glyph_q [DIGIT_COUNT];
  logic                dot_q [DIGIT_COUNT];
  int unsigned         scan_pos;
  logic                display_on;
  mdds_pkg::out_word_t scan_expect_q [$];
  int                  fails;

  task automatic store_glyph(input int pos, input logic [4:0] code);
    if (pos >= 0 && pos < DIGIT_COUNT) glyph_q[pos] = code;
  endtask

  task automatic apply_word(input mdds_pkg::in_word_t w);
    int unsigned         num;
    int                  pos;
    int unsigned         cnt;
    mdds_pkg::out_word_t res;
    case (w.operation)
      mdds_pkg::OP_TICK: begin
        if (display_on) begin
          scan_pos++;
          if (scan_pos >= DIGIT_COUNT) scan_pos = 0;
        end
        res.active_digit = 2'(scan_pos);
        res.digit_power  = display_on;
        res.active_code  = glyph_q[scan_pos];
        res.dot_level    = dot_q[scan_pos];
        scan_expect_q.push_back(res);
      end
      mdds_pkg::OP_WRITE_NUMBER: begin
        num = w.number;
        pos = w.position;
        cnt = w.digit_count;
        // digits least significant first, moving down from the start
        while (num > 0 && pos >= 0 && cnt > 0) begin
          store_glyph(pos, 5'(num % 10));
          num = num / 10;
          pos--;
          cnt--;
        end
        // zero padding once the number runs out
        while (cnt > 0 && pos >= 0) begin
          store_glyph(pos, 5'd0);
          pos--;
          cnt--;
        end
      end
      mdds_pkg::OP_WRITE_CODE:  store_glyph(w.position, w.glyph_code);
      mdds_pkg::OP_SET_DOT: begin
        if (w.position < DIGIT_COUNT) dot_q[w.position] = ~w.flag;
      end
      mdds_pkg::OP_SET_ENABLE:  display_on = w.flag;
      mdds_pkg::OP_BLANK_DIGIT: store_glyph(w.position, mdds_pkg::BLANK_CODE);
      default: ;
    endcase
  endtask

  task automatic check_scan_word(input mdds_pkg::out_word_t got);
    mdds_pkg::out_word_t exp;
    if (scan_expect_q.size() == 0) begin
      fails++;
      if (fails <= 10)
        $display("unexpected word: digit %0d power %0b code %0d dot %0b",
                 got.active_digit, got.digit_power,
                 got.active_code, got.dot_level);
    end else begin
      exp = scan_expect_q.pop_front();
      if (got.active_digit !== exp.active_digit || got.digit_power !== exp.digit_power ||
          got.active_code !== exp.active_code || got.dot_level !== exp.dot_level) begin
        fails++;
        if (fails <= 10)
          $display("mismatch: expected digit %0d power %0b code %0d dot %0b,",
                   exp.active_digit, exp.digit_power, exp.active_code, exp.dot_level,
                   " got digit %0d power %0b code %0d dot %0b",
                   got.active_digit, got.digit_power, got.active_code, got.dot_level);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIGIT_COUNT; i++) begin
        glyph_q[i] = mdds_pkg::BLANK_CODE;
        dot_q[i]   = 1'b1;
      end
      scan_pos   = 0;
      display_on = 1'b1;
      scan_expect_q.delete();
      fails = 0;
    end else begin
      // a result leaving now belongs to an earlier word
      if (out_valid && !out_stall) check_scan_word(out_data);
      if (in_valid && !in_stall) apply_word(in_data);
    end
    fail_count    <= fails;
    pending_words <= scan_expect_q.size();
  end

endmodule

/* tb/tb_multiplexed_digit_display_scanner_top.sv */
// ----------------------------------------------------------------------------
// tb_multiplexed_digit_display_scanner_top
// Drives directed and random words into the digit display scanner with
// random gaps and stalls on both channels, plus one long result hold-off
// that backs the block up. The checker beside the block predicts and
// compares every scan word; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_multiplexed_digit_display_scanner_top;

  localparam logic [2:0] OP_UNUSED_LO = 3'd6;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;
  localparam int RANDOM_WORDS = 820;
  localparam int HOLD_CYCLES  = 200;
  localparam int IDLE_LIMIT   = 3000;
  localparam int DRAIN_CYCLES = 12;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  mdds_pkg::in_word_t  in_data;
  logic                out_valid;
  logic                out_stall;
  mdds_pkg::out_word_t out_data;
  int                  fail_count;
  int                  pending_words;
  logic                hold_req;
  logic                no_gaps;

  multiplexed_digit_display_scanner_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  mdds_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .fail_count    (fail_count),
    .pending_words (pending_words)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic mdds_pkg::in_word_t make_word(input logic [2:0] op,
                                                   input logic [15:0] num,
                                                   input logic [1:0] pos,
                                                   input logic [2:0] cnt,
                                                   input logic [4:0] code,
                                                   input logic flag);
    mdds_pkg::in_word_t w;
    w.operation   = op;
    w.number      = num;
    w.position    = pos;
    w.digit_count = cnt;
    w.glyph_code  = code;
    w.flag        = flag;
    return w;
  endfunction

  function automatic mdds_pkg::in_word_t random_word();
    mdds_pkg::in_word_t w;
    int                 r;
    r = $urandom_range(0, 99);
    if (r < 35)      w.operation = mdds_pkg::OP_TICK;
    else if (r < 60) w.operation = mdds_pkg::OP_WRITE_NUMBER;
    else if (r < 70) w.operation = mdds_pkg::OP_WRITE_CODE;
    else if (r < 80) w.operation = mdds_pkg::OP_SET_DOT;
    else if (r < 88) w.operation = mdds_pkg::OP_SET_ENABLE;
    else if (r < 95) w.operation = mdds_pkg::OP_BLANK_DIGIT;
    else             w.operation = $urandom_range(0, 1) ? OP_UNUSED_LO : OP_UNUSED_HI;
    r = $urandom_range(0, 9);
    if (r < 4)       w.number = 16'($urandom_range(0, 99));
    else if (r < 8)  w.number = 16'($urandom);
    else if (r == 8) w.number = 16'd0;
    else             w.number = 16'hFFFF;
    w.position    = 2'($urandom_range(0, 3));
    w.digit_count = ($urandom_range(0, 99) < 85) ? 3'($urandom_range(0, 4))
                                                 : 3'($urandom_range(5, 7));
    w.glyph_code  = 5'($urandom_range(0, 31));
    // keep the display on most of the time so the scan keeps moving
    if (w.operation == mdds_pkg::OP_SET_ENABLE) w.flag = ($urandom_range(0, 3) != 0);
    else                                        w.flag = 1'($urandom_range(0, 1));
    return w;
  endfunction

  task automatic send_word(input mdds_pkg::in_word_t w);
    if (!no_gaps && $urandom_range(0, 99) < 40) begin
      in_valid = 1'b0;
      repeat (pick_gap()) @(negedge clk);
    end
    in_data  = w;
    in_valid = 1'b1;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    @(negedge clk);
  endtask

  // result side
  initial begin
    int r;
    bit took_hold;
    took_hold = 1'b0;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_req && !took_hold) begin
        took_hold = 1'b1;
        out_stall = 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 10) begin
          out_stall = 1'b0;
          repeat ($urandom_range(30, 120)) @(negedge clk);
        end else if (r < 65) begin
          out_stall = 1'b0;
        end else begin
          out_stall = 1'b1;
          repeat (pick_gap() - 1) @(negedge clk);
        end
      end
    end
  end

  // stimulus
  initial begin
    mdds_pkg::in_word_t w;
    int                 sent;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    hold_req = 1'b0;
    no_gaps  = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_word(make_word(mdds_pkg::OP_TICK, 16'd0, 2'd0, 3'd0, 5'd0, 1'b0));
    send_word(make_word(mdds_pkg::OP_WRITE_NUMBER, 16'hFFFF, 2'd3, 3'd4, 5'd31, 1'b1));
    send_word(make_word(mdds_pkg::OP_TICK, 16'd0, 2'd0, 3'd0, 5'd0, 1'b0));
    send_word(make_word(mdds_pkg::OP_WRITE_NUMBER, 16'd0, 2'd3, 3'd4, 5'd0, 1'b0));
    send_word(make_word(mdds_pkg::OP_WRITE_NUMBER, 16'd12, 2'd3, 3'd0, 5'd0, 1'b0));
    send_word(make_word(mdds_pkg::OP_WRITE_NUMBER, 16'd7, 2'd1, 3'd7, 5'd0, 1'b0));
    send_word(make_word(mdds_pkg::OP_WRITE_CODE, 16'd0, 2'd0, 3'd0, 5'd31, 1'b0));
    send_word(make_word(mdds_pkg::OP_WRITE_CODE, 16'hFFFF, 2'd3, 3'd7, 5'd0, 1'b1));
    send_word(make_word(mdds_pkg::OP_SET_DOT, 16'd0, 2'd2, 3'd0, 5'd0, 1'b1));
    send_word(make_word(mdds_pkg::OP_SET_DOT, 16'd0, 2'd0, 3'd0, 5'd0, 1'b0));
    send_word(make_word(mdds_pkg::OP_BLANK_DIGIT, 16'd0, 2'd1, 3'd0, 5'd0, 1'b0));
    repeat (4) send_word(make_word(mdds_pkg::OP_TICK, 16'd0, 2'd0, 3'd0, 5'd0, 1'b0));
    send_word(make_word(mdds_pkg::OP_SET_ENABLE, 16'd0, 2'd0, 3'd0, 5'd0, 1'b0));
    repeat (2) send_word(make_word(mdds_pkg::OP_TICK, 16'hFFFF, 2'd3, 3'd7, 5'd31, 1'b1));
    send_word(make_word(OP_UNUSED_LO, 16'd0, 2'd0, 3'd0, 5'd0, 1'b1));
    send_word(make_word(OP_UNUSED_HI, 16'hFFFF, 2'd3, 3'd7, 5'd31, 1'b0));
    send_word(make_word(mdds_pkg::OP_SET_ENABLE, 16'd0, 2'd0, 3'd0, 5'd0, 1'b1));
    send_word(make_word(mdds_pkg::OP_TICK, 16'd0, 2'd0, 3'd0, 5'd0, 1'b0));
    send_word(make_word(mdds_pkg::OP_WRITE_NUMBER, 16'd9999, 2'd2, 3'd3, 5'd0, 1'b0));
    repeat (2) send_word(make_word(mdds_pkg::OP_TICK, 16'd0, 2'd0, 3'd0, 5'd0, 1'b0));

    // back up the block behind a long result hold-off
    hold_req = 1'b1;
    no_gaps  = 1'b1;
    repeat (30) send_word(random_word());
    hold_req = 1'b0;

    sent = 0;
    while (sent < RANDOM_WORDS) begin
      no_gaps = ((sent / 50) % 4 == 3);
      w = random_word();
      send_word(w);
      if (w.operation != OP_UNUSED_LO && w.operation != OP_UNUSED_HI) sent++;
    end
    in_valid = 1'b0;

    while (pending_words != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_words == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // watchdog on cycles with no handshake on either channel
  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle = 0;
      else idle++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/mdds_pkg.sv
hw/rtl/mdds_ctrl.sv
hw/rtl/mdds_dpath.sv
hw/rtl/multiplexed_digit_display_scanner_top.sv
tb/mdds_checker.sv
tb/tb_multiplexed_digit_display_scanner_top.sv
